// ===== hw/rtl/hsf_pkg.sv =====
package hsf_pkg;

  // Input kinds carried on s_tuser
  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_LERR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_LENGTH  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [7:0]  HEADER_RESET  = 8'h59;
  localparam logic [4:0]  LENGTH_RESET  = 5'd7;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd3;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [8:0]  IDLE_MAX      = 9'h1FF;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [4:0] frame_len;      // clamped to 2..MAX_FRAME_BYTES
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_ACC,
    ST_REJECT,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage

// ===== hw/rtl/hsf_ram.sv =====
module hsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hsf_cfg.sv =====
module hsf_cfg #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output hsf_pkg::cfg_t cfg
);
  import hsf_pkg::*;

  logic [7:0] header_byte;
  logic [4:0] frame_length;
  logic [7:0] timeout_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte   <= HEADER_RESET;
      frame_length  <= LENGTH_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER:  header_byte   <= cfg_data;
        REG_LENGTH:  frame_length  <= cfg_data[4:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.header_byte   = header_byte;
    cfg.timeout_ticks = timeout_ticks;
    if (frame_length < 5'd2) begin
      cfg.frame_len = 5'd2;
    end else if (int'(frame_length) > MAX_FRAME_BYTES) begin
      cfg.frame_len = 5'(MAX_FRAME_BYTES);
    end else begin
      cfg.frame_len = frame_length;
    end
  end

endmodule

// ===== hw/rtl/header_sum_frame_receiver_unit.sv =====
// Channel  Dir  Beat fields (low bit up)
// s_*      in   tuser: func[1:0]; tdata: rx_data[7:0]
// m_*      out  tuser: status; tlast: last;
//               tdata: frame_byte[7:0], bad_frame_count[15:0], line_error_count[15:0]
// cfg_*    in   cfg_index[1:0] register, cfg_data[7:0] value; always ready
//
// A tick, a line error or a byte that does not finish a frame is taken in ST_IDLE.
// A finished frame is read back through the read port of the frame memory: each
// byte once to check the header and sum (ST_CHK_RD, ST_CHK_ACC), then, for a good
// frame, each byte again to emit it (ST_EMIT_RD, ST_EMIT_WR); a bad frame gives one
// rejection beat from ST_REJECT instead.
// A stalled m_tready holds the emitter; s_tready is low until the last beat of
// the frame sits in the output register.
// rst is synchronous; the frame memory needs no clearing pass.
module header_sum_frame_receiver_unit #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_data
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // frame_byte, bad_frame_count, line_error_count
  output logic        m_tuser,   // status
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import hsf_pkg::*;

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  cfg_t cfg;

  state_t        state, state_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [8:0]    idle_ticks, idle_ticks_next;
  logic [15:0]   bad_frames, bad_frames_next;
  logic [15:0]   line_errors, line_errors_next;
  logic [AW-1:0] idx, idx_next;
  logic [7:0]    sum, sum_next;
  logic          hdr_ok, hdr_ok_next;
  logic [4:0]    flen, flen_next;

  logic        out_valid, out_valid_next;
  logic        out_status, out_status_next;
  logic        out_last, out_last_next;
  logic [7:0]  out_byte, out_byte_next;
  logic [15:0] out_bad, out_bad_next;
  logic [15:0] out_lerr, out_lerr_next;

  logic          mem_we, mem_re;
  logic [7:0]    mem_rdata;
  logic          in_fire, out_free, idx_last;
  logic [CW-1:0] count_inc;
  logic [8:0]    idle_inc;
  logic [15:0]   bad_inc, lerr_inc;

  hsf_cfg #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  hsf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(byte_count[AW-1:0]),
    .wdata(s_tdata),
    .re   (mem_re),
    .raddr(idx),
    .rdata(mem_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign idx_last = (int'(idx) == int'(flen) - 1);

  assign count_inc = (int'(byte_count) < MAX_FRAME_BYTES) ? byte_count + CW'(1) : byte_count;
  assign idle_inc  = (idle_ticks != IDLE_MAX) ? idle_ticks + 9'd1 : idle_ticks;
  assign bad_inc   = (bad_frames != COUNT_MAX) ? bad_frames + 16'd1 : bad_frames;
  assign lerr_inc  = (line_errors != COUNT_MAX) ? line_errors + 16'd1 : line_errors;

  assign mem_we = in_fire && (s_tuser == FUNC_BYTE) &&
                  (int'(byte_count) < MAX_FRAME_BYTES);
  assign mem_re = (state == ST_CHK_RD) || (state == ST_EMIT_RD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      byte_count  <= '0;
      idle_ticks  <= '0;
      bad_frames  <= '0;
      line_errors <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      byte_count  <= byte_count_next;
      idle_ticks  <= idle_ticks_next;
      bad_frames  <= bad_frames_next;
      line_errors <= line_errors_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    sum        <= sum_next;
    hdr_ok     <= hdr_ok_next;
    flen       <= flen_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
    out_byte   <= out_byte_next;
    out_bad    <= out_bad_next;
    out_lerr   <= out_lerr_next;
  end

  always_comb begin
    state_next       = state;
    byte_count_next  = byte_count;
    idle_ticks_next  = idle_ticks;
    bad_frames_next  = bad_frames;
    line_errors_next = line_errors;
    idx_next         = idx;
    sum_next         = sum;
    hdr_ok_next      = hdr_ok;
    flen_next        = flen;
    out_valid_next   = out_valid && !m_tready;
    out_status_next  = out_status;
    out_last_next    = out_last;
    out_byte_next    = out_byte;
    out_bad_next     = out_bad;
    out_lerr_next    = out_lerr;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_tuser)
            FUNC_BYTE: begin
              idle_ticks_next = '0;
              if (int'(count_inc) >= int'(cfg.frame_len)) begin
                byte_count_next = '0;
                flen_next       = cfg.frame_len;
                idx_next        = '0;
                sum_next        = '0;
                hdr_ok_next     = 1'b0;
                state_next      = ST_CHK_RD;
              end else begin
                byte_count_next = count_inc;
              end
            end
            FUNC_TICK: begin
              if (byte_count != '0) begin
                // drop the partial frame once it has sat too long
                if (idle_inc > {1'b0, cfg.timeout_ticks}) begin
                  byte_count_next = '0;
                  idle_ticks_next = '0;
                end else begin
                  idle_ticks_next = idle_inc;
                end
              end
            end
            FUNC_LERR: begin
              line_errors_next = lerr_inc;
              idle_ticks_next  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CHK_RD: begin
        state_next = ST_CHK_ACC;
      end
      ST_CHK_ACC: begin
        if (idx == '0) begin
          hdr_ok_next = (mem_rdata == cfg.header_byte);
        end
        if (idx_last) begin
          idx_next = '0;
          if (hdr_ok && (sum == mem_rdata)) begin
            state_next = ST_EMIT_RD;
          end else begin
            state_next = ST_REJECT;
          end
        end else begin
          sum_next   = sum + mem_rdata;
          idx_next   = idx + AW'(1);
          state_next = ST_CHK_RD;
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          bad_frames_next = bad_inc;
          out_valid_next  = 1'b1;
          out_status_next = 1'b1;
          out_byte_next   = '0;
          out_last_next   = 1'b1;
          out_bad_next    = bad_inc;
          out_lerr_next   = line_errors;
          state_next      = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        // read data holds until the output register takes it
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = 1'b0;
          out_byte_next   = mem_rdata;
          out_last_next   = idx_last;
          out_bad_next    = bad_frames;
          out_lerr_next   = line_errors;
          if (idx_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_lerr, out_bad, out_byte};

endmodule

// ===== hw/rtl/hsf_checker.sv =====
module hsf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a rejection beat carries no byte and closes its run
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'd0 && m_tlast))
    else $error("rejection beat with data or without last");

  // the input side stays closed while a good frame is still being sent
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && !m_tlast) |-> !s_tready)
    else $error("input accepted in the middle of a frame");

  // the bad-frame count never falls between shown beats
  a_bad_monotonic: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && $past(m_tvalid) && !$past(rst)) |->
      (m_tdata[23:8] >= $past(m_tdata[23:8])))
    else $error("bad-frame count decreased");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output beat changed");

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind header_sum_frame_receiver_unit hsf_checker u_hsf_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// ===== verif/tb_header_sum_frame_receiver_unit.sv =====
module tb_header_sum_frame_receiver_unit;
  import hsf_pkg::*;

  localparam int unsigned MAX_BYTES     = 16;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // codes outside the defined lists
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  typedef struct {
    logic        status;
    logic [7:0]  frame_byte;
    logic        last;
    logic [15:0] bad_frames;
    logic [15:0] line_errors;
  } frame_beat_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data;
    logic        typed;
    logic        status;
    logic [7:0]  frame_byte;
    logic        last;
    logic [15:0] bad_frames;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_data
  logic [1:0]  s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // frame_byte, bad_frame_count, line_error_count
  logic        m_tuser;   // status
  logic        m_tlast;   // last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  header_sum_frame_receiver_unit #(.MAX_FRAME_BYTES(MAX_BYTES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // receiver state mirrored on the bench side
  logic [7:0]  frame_mem [MAX_BYTES];
  int unsigned fill_cnt;
  logic [8:0]  idle_cnt;
  logic [15:0] bad_cnt;
  logic [15:0] lerr_cnt;
  logic [7:0]  hdr_cfg;
  logic [4:0]  len_cfg;
  logic [7:0]  tmo_cfg;

  frame_beat_t frame_beats_due [$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_req;
  int unsigned items_sent;
  int unsigned err_count;
  int unsigned cycle_cnt;

  stim_row_t dir_rows [24] = '{
    '{FUNC_UNUSED, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_LERR,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_TICK,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    // good frame at reset settings
    '{FUNC_BYTE,   8'h59, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h5E, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    // wrong checksum
    '{FUNC_BYTE,   8'h59, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h05, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_BYTE,   8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 16'd1},
    // line error restarts the idle timer, fourth tick after it drops the frame
    '{FUNC_BYTE,   8'h59, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_TICK,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_LERR,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_TICK,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_TICK,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_TICK,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{FUNC_TICK,   8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0}
  };

  function automatic int unsigned eff_len();
    if (len_cfg < 5'd2) return 2;
    if (len_cfg > MAX_BYTES) return MAX_BYTES;
    return 32'(len_cfg);
  endfunction

  // advance the mirrored receiver by one input beat and queue what it emits
  function automatic void assemble_frame(input logic [1:0] f, input logic [7:0] d);
    int unsigned len;
    logic [7:0]  sum;
    bit          good;
    frame_beat_t beat;
    case (f)
      FUNC_TICK: begin
        if (fill_cnt > 0) begin
          if (idle_cnt < IDLE_MAX) idle_cnt++;
          if (idle_cnt > tmo_cfg) begin
            fill_cnt = 0;
            idle_cnt = '0;
          end
        end
      end
      FUNC_LERR: begin
        if (lerr_cnt != COUNT_MAX) lerr_cnt++;
        idle_cnt = '0;
      end
      FUNC_BYTE: begin
        if (fill_cnt < MAX_BYTES) begin
          frame_mem[fill_cnt] = d;
          fill_cnt++;
        end
        idle_cnt = '0;
        len = eff_len();
        if (fill_cnt >= len) begin
          sum = '0;
          for (int i = 0; i < len - 1; i++) sum += frame_mem[i];
          good = (frame_mem[0] == hdr_cfg) && (sum == frame_mem[len-1]);
          fill_cnt = 0;
          if (!good) begin
            if (bad_cnt != COUNT_MAX) bad_cnt++;
            beat = '{1'b1, 8'h00, 1'b1, bad_cnt, lerr_cnt};
            frame_beats_due.push_back(beat);
          end else begin
            for (int i = 0; i < len; i++) begin
              beat = '{1'b0, frame_mem[i], (i == len - 1), bad_cnt, lerr_cnt};
              frame_beats_due.push_back(beat);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_on) begin
        m_tready <= ($urandom_range(0, 99) >= 30);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (frame_beats_due.size() == 0) begin
        $error("output beat with nothing pending: tdata 0x%0h", m_tdata);
        err_count++;
      end else begin
        want = frame_beats_due.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("frame_byte", want.frame_byte, m_tdata[7:0]);
        check_field("last", want.last, m_tlast);
        check_field("bad_frame_count", want.bad_frames, m_tdata[23:8]);
        check_field("line_error_count", want.line_errors, m_tdata[39:24]);
      end
    end
  end

  task automatic send_beat(input logic [1:0] f, input logic [7:0] d);
    if (tx_idle_on && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    assemble_frame(f, d);
    if (f != FUNC_UNUSED) items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HEADER:  hdr_cfg = val;
      REG_LENGTH:  len_cfg = val[4:0];
      REG_TIMEOUT: tmo_cfg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [7:0] len,
                            input logic [7:0] tmo);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_LENGTH, len);
    write_reg(REG_TIMEOUT, tmo);
  endtask

  // hold the sender until every pending beat is out, then let the block settle
  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input bit corrupt);
    logic [7:0]  bytes [MAX_BYTES];
    logic [7:0]  sum;
    int unsigned n;
    n = eff_len();
    bytes[0] = hdr_cfg;
    sum = hdr_cfg;
    for (int i = 1; i < n - 1; i++) begin
      bytes[i] = 8'($urandom_range(0, 255));
      sum += bytes[i];
    end
    bytes[n-1] = sum;
    if (corrupt) begin
      if ($urandom_range(0, 1) == 0) bytes[0] ^= 8'($urandom_range(1, 255));
      else bytes[n-1] ^= 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < n; i++) send_beat(FUNC_BYTE, bytes[i]);
  endtask

  // start a frame and let it age: at or one tick past a timeout up to 20, else one tick past it or 0..3 ticks
  task automatic send_partial();
    int unsigned k;
    int unsigned ticks;
    k = $urandom_range(1, eff_len() - 1);
    send_beat(FUNC_BYTE, hdr_cfg);
    repeat (k - 1) send_beat(FUNC_BYTE, 8'($urandom_range(0, 255)));
    if (tmo_cfg <= 8'd20) ticks = tmo_cfg + $urandom_range(0, 1);
    else if ($urandom_range(0, 3) == 0) ticks = tmo_cfg + 1;
    else ticks = $urandom_range(0, 3);
    repeat (ticks) send_beat(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_mix(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_frame(1'b0);
      else if (pick < 72) send_frame(1'b1);
      else if (pick < 80) send_partial();
      else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) send_beat(FUNC_TICK, 8'($urandom_range(0, 255)));
      end
      else if (pick < 94) send_beat(FUNC_LERR, 8'($urandom_range(0, 255)));
      else if (pick < 97) send_beat(FUNC_UNUSED, 8'($urandom_range(0, 255)));
      else send_beat(FUNC_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    frame_beat_t beat;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int i = 0; i < MAX_BYTES; i++) frame_mem[i] = '0;
    fill_cnt   = 0;
    idle_cnt   = '0;
    bad_cnt    = '0;
    lerr_cnt   = '0;
    hdr_cfg    = HEADER_RESET;
    len_cfg    = LENGTH_RESET;
    tmo_cfg    = TIMEOUT_RESET;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 0;
    items_sent = 0;
    err_count  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].func, dir_rows[i].data);
      if (dir_rows[i].typed) begin
        beat = frame_beats_due.pop_back();
        beat.status     = dir_rows[i].status;
        beat.frame_byte = dir_rows[i].frame_byte;
        beat.last       = dir_rows[i].last;
        beat.bad_frames = dir_rows[i].bad_frames;
        frame_beats_due.push_back(beat);
      end
    end
    drain_block();

    run_mix(16);
    drain_block();

    set_config(8'h00, 8'd2, 8'd0);
    run_mix(16);
    drain_block();

    set_config(8'hFF, 8'd16, 8'hFF);
    run_mix(16);
    // stall the output while full-length frames keep coming
    tx_idle_on = 1'b0;
    hold_req++;
    repeat (3) send_frame(1'b0);
    tx_idle_on = 1'b1;
    drain_block();

    write_reg(REG_UNUSED, 8'hFF);
    set_config(8'hA5, 8'd0, 8'd1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_mix(16);
    drain_block();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    set_config(8'h3C, 8'hE5, 8'd7);
    run_mix(16);
    drain_block();

    set_config(8'($urandom_range(0, 255)), 8'd1, 8'd2);
    run_mix(12);
    drain_block();

    set_config(8'($urandom_range(0, 255)), 8'h1F, 8'd4);
    run_mix(12);
    drain_block();

    // shrink the frame length under a partly filled frame
    set_config(8'h59, 8'd16, 8'hFF);
    send_beat(FUNC_BYTE, 8'h59);
    send_beat(FUNC_BYTE, 8'h10);
    send_beat(FUNC_BYTE, 8'h69);
    send_beat(FUNC_BYTE, 8'h33);
    send_beat(FUNC_BYTE, 8'h44);
    drain_block();
    write_reg(REG_LENGTH, 8'd3);
    send_beat(FUNC_BYTE, 8'h77);
    drain_block();

    // short frames back to back, good and bad, around a line error
    set_config(8'h59, 8'd2, 8'd3);
    send_frame(1'b0);
    send_frame(1'b1);
    send_beat(FUNC_LERR, 8'($urandom_range(0, 255)));
    send_frame(1'b0);
    drain_block();

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
